@@ rtl/bbce_pkg.sv @@
// Shared constants, codes and types of the bitmap byte color expander.
package bbce_pkg;

    // Color attribute ROM geometry.
    localparam int COLOR_ROM_DEPTH = 2048;
    localparam int ROM_AW          = $clog2(COLOR_ROM_DEPTH);
    // Lookup sums stay below twice the depth, so one extra bit holds them.
    localparam int LOOKUP_W        = ROM_AW + 1;

    // Input and result field widths.
    localparam int ADDR_W      = 13;
    localparam int DATA_W      = 8;
    localparam int COORD_W     = 8;
    localparam int COLOR_W     = 4;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 24;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_COLOR_MODE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FLIP_SCREEN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_A     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_B     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_C     = 3'd4;

    // Color ROM layouts; any other code uses the 16x8 layout.
    localparam logic [1:0] MODE_8X16   = 2'd0;
    localparam logic [1:0] MODE_16X16  = 2'd1;
    localparam logic [1:0] MODE_16X8   = 2'd2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    // Input word kinds carried on tuser.
    localparam logic ACT_VIDEO      = 1'b0;
    localparam logic ACT_COLOR_LOAD = 1'b1;

    // Queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic [1:0] color_mode;
        logic       flip_screen;
        logic       color_reg_a;
        logic       color_reg_b;
        logic       color_reg_c;
    } cfg_t;

    // One video byte ready for expansion into eight pixels.
    typedef struct packed {
        logic [4:0]         column;
        logic [COORD_W-1:0] line;
        logic [DATA_W-1:0]  bits;
        logic [COLOR_W-1:0] color;
        logic               flip;
    } item_t;

endpackage

@@ rtl/bbce_front.sv @@
// Front end: accepts words, loads the color ROM and looks up the color of video bytes.
module bbce_front
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  bbce_pkg::cfg_t               cfg,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         in_action,
    input  logic [bbce_pkg::ADDR_W-1:0]  in_address,
    input  logic [bbce_pkg::DATA_W-1:0]  in_data,
    output logic                         push,
    output bbce_pkg::item_t              push_item,
    input  logic                         queue_full
);

    logic [bbce_pkg::DATA_W-1:0] rom_mem [bbce_pkg::COLOR_ROM_DEPTH];
    logic [bbce_pkg::DATA_W-1:0] rd_data_reg;
    logic                        s1_valid_reg;
    logic                        s1_valid_next;
    logic                        s1_high_reg;
    bbce_pkg::item_t             s1_item_reg;
    logic                        accept;
    logic                        video_acc;
    logic                        load_acc;
    logic [11:0]                 lookup_raw;
    logic [bbce_pkg::LOOKUP_W-1:0] lookup_addr;
    logic                        load_in_range;

    // The stage register frees up when it is empty or hands its word to the queue.
    assign in_ready  = !s1_valid_reg || !queue_full;
    assign accept    = in_valid && in_ready;
    assign video_acc = accept && (in_action == bbce_pkg::ACT_VIDEO);
    assign load_acc  = accept && (in_action == bbce_pkg::ACT_COLOR_LOAD);
    assign load_in_range =
        in_address < bbce_pkg::ADDR_W'(bbce_pkg::COLOR_ROM_DEPTH);

    // Color ROM address from the byte offset: x/16 is address[4:1], x/8 is address[4:0],
    // y/8 is address[12:8] and y/16 is address[12:9]; the fields do not overlap.
    always_comb
    begin
        case (cfg.color_mode)
            bbce_pkg::MODE_8X16:
                lookup_raw = 12'({cfg.color_reg_c, cfg.color_reg_a,
                                  in_address[4:1], in_address[12:8]});
            bbce_pkg::MODE_16X16:
                lookup_raw = 12'({cfg.color_reg_b, cfg.color_reg_a,
                                  in_address[12:9], in_address[4:1]});
            default:
                lookup_raw = 12'({in_address[4:0], in_address[12:9]});
        endcase
        lookup_addr = bbce_pkg::LOOKUP_W'(lookup_raw);
        if (lookup_addr >= bbce_pkg::LOOKUP_W'(bbce_pkg::COLOR_ROM_DEPTH))
        begin
            lookup_addr = lookup_addr - bbce_pkg::LOOKUP_W'(bbce_pkg::COLOR_ROM_DEPTH);
        end
    end

    // Color ROM: one write port for loads, one registered read for video bytes.
    always_ff @(posedge clk)
    begin
        if (load_acc && load_in_range)
        begin
            rom_mem[in_address[bbce_pkg::ROM_AW-1:0]] <= in_data;
        end
        if (video_acc)
        begin
            rd_data_reg <= rom_mem[lookup_addr[bbce_pkg::ROM_AW-1:0]];
        end
    end

    // Payload of the lookup stage.
    always_ff @(posedge clk)
    begin
        if (video_acc)
        begin
            s1_item_reg.column <= in_address[4:0];
            s1_item_reg.line   <= in_address[12:5];
            s1_item_reg.bits   <= in_data;
            s1_item_reg.color  <= '0;
            s1_item_reg.flip   <= cfg.flip_screen;
            s1_high_reg        <= (cfg.color_mode != bbce_pkg::MODE_16X16) && cfg.color_reg_b;
        end
    end

    // Stage occupancy.
    assign push          = s1_valid_reg && !queue_full;
    assign s1_valid_next = (s1_valid_reg && !push) || video_acc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    // Nibble select completes the word handed to the queue.
    always_comb
    begin
        push_item       = s1_item_reg;
        push_item.color = s1_high_reg ? rd_data_reg[7:4] : rd_data_reg[3:0];
    end

endmodule

@@ rtl/bbce_queue.sv @@
// Short queue of looked-up video bytes between the front end and the pixel sequencer.
module bbce_queue
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  bbce_pkg::item_t push_item,
    output logic            full,
    input  logic            pop,
    output logic            not_empty,
    output bbce_pkg::item_t pop_item
);

    bbce_pkg::item_t                 entry_mem [bbce_pkg::QUEUE_DEPTH];
    logic [bbce_pkg::QUEUE_AW-1:0]   wr_ptr_reg;
    logic [bbce_pkg::QUEUE_AW-1:0]   rd_ptr_reg;
    logic [bbce_pkg::QUEUE_AW:0]     count_reg;
    logic [bbce_pkg::QUEUE_AW:0]     count_next;

    assign full      = count_reg == (bbce_pkg::QUEUE_AW + 1)'(bbce_pkg::QUEUE_DEPTH);
    assign not_empty = count_reg != '0;
    assign pop_item  = entry_mem[rd_ptr_reg];

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_mem[wr_ptr_reg] <= push_item;
        end
    end

    // Pointers and fill count.
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == bbce_pkg::QUEUE_AW'(bbce_pkg::QUEUE_DEPTH - 1))
                              ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == bbce_pkg::QUEUE_AW'(bbce_pkg::QUEUE_DEPTH - 1))
                              ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

@@ rtl/bbce_back.sv @@
// Pixel sequencer: expands each video byte into eight pixel words, most significant bit first.
module bbce_back
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          not_empty,
    input  bbce_pkg::item_t               pop_item,
    output logic                          pop,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [bbce_pkg::COORD_W-1:0]  pixel_x,
    output logic [bbce_pkg::COORD_W-1:0]  pixel_y,
    output logic [bbce_pkg::COLOR_W-1:0]  pixel_color,
    output logic                          last_pixel
);

    logic            active_reg;
    logic [2:0]      idx_reg;
    bbce_pkg::item_t cur_reg;
    logic            out_acc;
    logic            finishing;
    logic [7:0]      raw_x;

    assign out_acc   = active_reg && out_ready;
    assign finishing = out_acc && (idx_reg == 3'd7);
    assign pop       = not_empty && (!active_reg || finishing);

    // Sequencer state: a queued byte follows the eighth pixel without a gap.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            idx_reg    <= '0;
        end
        else
        begin
            if (pop)
            begin
                active_reg <= 1'b1;
                idx_reg    <= '0;
            end
            else if (finishing)
            begin
                active_reg <= 1'b0;
                idx_reg    <= '0;
            end
            else if (out_acc)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= pop_item;
        end
    end

    // Pixel word: x is the byte column times eight plus the pixel index.
    // Flipping 255 - v on eight bits is a bitwise inversion.
    assign raw_x       = {cur_reg.column, idx_reg};
    assign out_valid   = active_reg;
    assign pixel_x     = cur_reg.flip ? ~raw_x : raw_x;
    assign pixel_y     = cur_reg.flip ? ~cur_reg.line : cur_reg.line;
    assign pixel_color = cur_reg.bits[3'd7 - idx_reg] ? cur_reg.color : '0;
    assign last_pixel  = idx_reg == 3'd7;

endmodule

@@ rtl/bitmap_byte_color_expander.sv @@
// Top level of the bitmap byte color expander: configuration registers and the three parts.
// A video word passes the lookup stage and the queue before its first pixel is valid.
// Pixel words leave one per cycle while the sequencer holds a byte and m_axis_tready is high;
// each video word yields eight pixel words, so the sequencer sets the sustained input rate.
// Input words are taken back to back until the lookup stage and the two-entry queue are full.
// Reset clears the configuration registers and all control state; the color ROM is not cleared.
module bitmap_byte_color_expander
(
    input  logic                                clk,
    input  logic                                rst_n,
    // Input stream.
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [bbce_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // address[12:0], data_byte[20:13]
    input  logic                                s_axis_tuser,  // action[0]
    // Pixel stream.
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [bbce_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,  // pixel_x[7:0], pixel_y[15:8],
                                                               // pixel_color[19:16]
    output logic                                m_axis_tlast,  // last_pixel
    // Configuration writes.
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bbce_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bbce_pkg::CFG_DATA_W-1:0]     cfg_data
);

    bbce_pkg::cfg_t                  cfg_reg;
    logic                            push;
    bbce_pkg::item_t                 push_item;
    logic                            queue_full;
    logic                            pop;
    logic                            not_empty;
    bbce_pkg::item_t                 pop_item;
    logic [bbce_pkg::COORD_W-1:0]    pixel_x;
    logic [bbce_pkg::COORD_W-1:0]    pixel_y;
    logic [bbce_pkg::COLOR_W-1:0]    pixel_color;

    // Configuration registers; unknown indexes are dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                bbce_pkg::REG_COLOR_MODE:  cfg_reg.color_mode  <= cfg_data;
                bbce_pkg::REG_FLIP_SCREEN: cfg_reg.flip_screen <= cfg_data[0];
                bbce_pkg::REG_COLOR_A:     cfg_reg.color_reg_a <= cfg_data[0];
                bbce_pkg::REG_COLOR_B:     cfg_reg.color_reg_b <= cfg_data[0];
                bbce_pkg::REG_COLOR_C:     cfg_reg.color_reg_c <= cfg_data[0];
                default: ;
            endcase
        end
    end

    bbce_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_action  (s_axis_tuser),
        .in_address (s_axis_tdata[12:0]),
        .in_data    (s_axis_tdata[20:13]),
        .push       (push),
        .push_item  (push_item),
        .queue_full (queue_full)
    );

    bbce_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (queue_full),
        .pop       (pop),
        .not_empty (not_empty),
        .pop_item  (pop_item)
    );

    bbce_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .not_empty   (not_empty),
        .pop_item    (pop_item),
        .pop         (pop),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .pixel_color (pixel_color),
        .last_pixel  (m_axis_tlast)
    );

    // Pack the pixel word; the unused top bits are zero.
    assign m_axis_tdata = {4'b0, pixel_color, pixel_y, pixel_x};

endmodule

@@ rtl/bbce_check.sv @@
// Port-level checker for the bitmap byte color expander, bound to the top level.
module bbce_check
(
    input logic                             clk,
    input logic                             rst_n,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [bbce_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                             m_axis_tlast
);

    // A stalled pixel word holds its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("pixel word changed while stalled");

    // Within a byte the next pixel is always ready right away.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
    else $error("gap inside the eight pixels of a byte");

    // The last pixel sits at the right edge of its byte, or the left edge when flipped.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |->
            (m_axis_tdata[2:0] == 3'd7) || (m_axis_tdata[2:0] == 3'd0))
    else $error("last pixel at a wrong column");

    // Nothing is offered right after reset is released.
    assert property (@(posedge clk) $rose(rst_n) |-> !m_axis_tvalid)
    else $error("pixel word valid out of reset");

endmodule

bind bitmap_byte_color_expander bbce_check u_bbce_check
(
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

@@ bench/tb_bitmap_byte_color_expander.sv @@
// Self-checking testbench for the bitmap byte color expander.
module tb_bitmap_byte_color_expander;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT  = 3000;
    localparam int SINK_HOLD    = 150;
    localparam int SETTLE_TIME  = 4;
    localparam int MAX_REPORTS  = 40;
    localparam int PHASE_COUNT  = 10;
    localparam int PHASE_WORDS  = 24;

    // One expected pixel word.
    typedef struct {
        logic [bbce_pkg::COORD_W-1:0] x;
        logic [bbce_pkg::COORD_W-1:0] y;
        logic [bbce_pkg::COLOR_W-1:0] color;
        logic                         last;
    } pixel_t;

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             s_axis_tvalid = 1'b0;
    logic                             s_axis_tready;
    logic [bbce_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                             s_axis_tuser = bbce_pkg::ACT_VIDEO;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready = 1'b0;
    logic [bbce_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic                             m_axis_tlast;
    logic                             cfg_valid = 1'b0;
    logic                             cfg_ready;
    logic [bbce_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
    logic [bbce_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

    // Mirror of the attribute ROM, the registers and the pixels still owed.
    logic [7:0]     attr_rom [bbce_pkg::COLOR_ROM_DEPTH];
    bit             attr_loaded [bbce_pkg::COLOR_ROM_DEPTH];
    bbce_pkg::cfg_t shadow_cfg = '0;
    pixel_t         pending_pixels [$];

    bit idle_en = 1'b1;
    int sink_hold = 0;
    int mismatches = 0;
    int video_words = 0;
    int color_loads = 0;
    int pixels_checked = 0;
    int settings_used = 1;

    bitmap_byte_color_expander i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // address[12:0], data_byte[20:13]
        .s_axis_tuser  (s_axis_tuser),   // action[0]
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // pixel_x[7:0], pixel_y[15:8], pixel_color[19:16]
        .m_axis_tlast  (m_axis_tlast),   // last_pixel
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #1 clk = ~clk;

    // Attribute ROM index that a video offset reads under the current settings.
    function automatic int unsigned attr_index(input logic [bbce_pkg::ADDR_W-1:0] offset);
        int unsigned x;
        int unsigned y;
        int unsigned sum;
        x = 8 * offset[4:0];
        y = offset[12:5];
        case (shadow_cfg.color_mode)
            bbce_pkg::MODE_8X16:
                sum = 'h200 * shadow_cfg.color_reg_a + 'h400 * shadow_cfg.color_reg_c
                    + (x / 16) * 32 + y / 8;
            bbce_pkg::MODE_16X16:
                sum = 'h100 * shadow_cfg.color_reg_a + 'h200 * shadow_cfg.color_reg_b
                    + (y / 16) * 16 + x / 16;
            default:
                sum = (x / 8) * 16 + y / 16;
        endcase
        return sum % bbce_pkg::COLOR_ROM_DEPTH;
    endfunction

    // Apply one accepted input word: load the ROM or queue its eight pixels.
    task automatic expand_word(input logic act, input logic [bbce_pkg::ADDR_W-1:0] addr,
                               input logic [bbce_pkg::DATA_W-1:0] bits);
        pixel_t                       p;
        logic [7:0]                   attr;
        logic [bbce_pkg::COLOR_W-1:0] color;
        logic [bbce_pkg::COORD_W-1:0] x;
        logic [bbce_pkg::COORD_W-1:0] y;
        if (act == bbce_pkg::ACT_COLOR_LOAD) begin
            color_loads++;
            if (addr < bbce_pkg::COLOR_ROM_DEPTH) begin
                attr_rom[addr[bbce_pkg::ROM_AW-1:0]]    = bits;
                attr_loaded[addr[bbce_pkg::ROM_AW-1:0]] = 1'b1;
            end
        end
        else begin
            video_words++;
            attr = attr_rom[attr_index(addr)];
            // Mode 1 always takes the low nibble; the others follow color_reg_b.
            if (shadow_cfg.color_mode != bbce_pkg::MODE_16X16 && shadow_cfg.color_reg_b)
                color = attr[7:4];
            else
                color = attr[3:0];
            y = addr[12:5];
            for (int i = 0; i < 8; i++) begin
                x       = bbce_pkg::COORD_W'({addr[4:0], 3'b000} + i);
                p.x     = shadow_cfg.flip_screen ? 8'd255 - x : x;
                p.y     = shadow_cfg.flip_screen ? 8'd255 - y : y;
                p.color = bits[7-i] ? color : '0;
                p.last  = (i == 7);
                pending_pixels.push_back(p);
            end
        end
    endtask

    // Offer one word, after a random gap when idle_en is set, and hold it until it is taken.
    task automatic send_word(input logic act, input logic [bbce_pkg::ADDR_W-1:0] addr,
                             input logic [bbce_pkg::DATA_W-1:0] bits);
        int gap;
        gap = idle_en ? $urandom_range(0, 6) : 0;
        if (gap > 0)
        begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tdata  = {3'b000, bits, addr};
        s_axis_tuser  = act;
        s_axis_tvalid = 1'b1;
        do @(posedge clk); while (!s_axis_tready);
        expand_word(act, addr, bits);
        @(negedge clk);
        s_axis_tvalid = 1'b0;
    endtask

    // A video word; the ROM entry it reads is loaded first if it never was.
    task automatic send_video(input logic [bbce_pkg::ADDR_W-1:0] offset,
                              input logic [bbce_pkg::DATA_W-1:0] bits);
        int unsigned idx;
        idx = attr_index(offset);
        if (!attr_loaded[idx])
            send_word(bbce_pkg::ACT_COLOR_LOAD, bbce_pkg::ADDR_W'(idx),
                      bbce_pkg::DATA_W'($urandom_range(0, 255)));
        send_word(bbce_pkg::ACT_VIDEO, offset, bits);
    endtask

    task automatic write_reg(input logic [bbce_pkg::CFG_IDX_W-1:0] idx,
                             input logic [bbce_pkg::CFG_DATA_W-1:0] val);
        cfg_index = idx;
        cfg_data  = val;
        cfg_valid = 1'b1;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            bbce_pkg::REG_COLOR_MODE:  shadow_cfg.color_mode  = val;
            bbce_pkg::REG_FLIP_SCREEN: shadow_cfg.flip_screen = val[0];
            bbce_pkg::REG_COLOR_A:     shadow_cfg.color_reg_a = val[0];
            bbce_pkg::REG_COLOR_B:     shadow_cfg.color_reg_b = val[0];
            bbce_pkg::REG_COLOR_C:     shadow_cfg.color_reg_c = val[0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Write all five registers; the unused upper data bit of the flags is random.
    task automatic set_config(input logic [1:0] mode, input logic flip, input logic a,
                              input logic b, input logic c);
        write_reg(bbce_pkg::REG_COLOR_MODE, mode);
        write_reg(bbce_pkg::REG_FLIP_SCREEN, {1'($urandom_range(0, 1)), flip});
        write_reg(bbce_pkg::REG_COLOR_A, {1'($urandom_range(0, 1)), a});
        write_reg(bbce_pkg::REG_COLOR_B, {1'($urandom_range(0, 1)), b});
        write_reg(bbce_pkg::REG_COLOR_C, {1'($urandom_range(0, 1)), c});
        settings_used++;
    endtask

    // Wait for every owed pixel, then let a trailing color load settle.
    task automatic wait_drained();
        while (pending_pixels.size() != 0) @(negedge clk);
        repeat (SETTLE_TIME) @(negedge clk);
    endtask

    // Field extremes, ignored loads and each ROM layout at its corner offsets.
    task automatic test_directed();
        send_word(bbce_pkg::ACT_COLOR_LOAD, 13'd0, 8'h3C);
        send_word(bbce_pkg::ACT_COLOR_LOAD, 13'd2048, 8'hFF);
        send_word(bbce_pkg::ACT_COLOR_LOAD, 13'd8191, 8'hE1);
        send_word(bbce_pkg::ACT_COLOR_LOAD, 13'd2047, 8'h9A);
        send_video(13'd0, 8'hFF);
        send_video(13'd0, 8'h80);
        send_video(13'd0, 8'h01);
        send_video(13'd8191, 8'h00);
        send_video(13'd8191, 8'hA5);
        send_video(13'd31, 8'h5A);
        send_video(13'd8160, 8'hFF);
        wait_drained();
        // Highest bank in the 8x16 layout reaches the top ROM entry.
        set_config(bbce_pkg::MODE_8X16, 1'b1, 1'b1, 1'b1, 1'b1);
        send_video(13'd8191, 8'hFF);
        send_video(13'd0, 8'hC3);
        wait_drained();
        set_config(bbce_pkg::MODE_16X16, 1'b0, 1'b1, 1'b1, 1'b0);
        send_video(13'd8191, 8'hFF);
        send_video(13'd0, 8'h81);
        wait_drained();
        set_config(bbce_pkg::MODE_16X8, 1'b0, 1'b0, 1'b1, 1'b0);
        send_video(13'd8191, 8'hFF);
        send_video(13'd0, 8'h7E);
        wait_drained();
        // The unused layout code falls back to the 16x8 layout.
        set_config(bbce_pkg::MODE_UNUSED, 1'b1, 1'b0, 1'b0, 1'b0);
        send_video(13'd8191, 8'h7E);
        send_video(13'd4000, 8'hFF);
        wait_drained();
    endtask

    // Random words under a series of register settings, extremes first.
    task automatic test_random_phases();
        logic [1:0]                  mode;
        logic                        flip, a, b, c;
        logic [bbce_pkg::ADDR_W-1:0] addr;
        logic [bbce_pkg::DATA_W-1:0] bits;
        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            case (ph)
                0: begin mode = bbce_pkg::MODE_8X16; {flip, a, b, c} = 4'b0000; end
                1: begin mode = bbce_pkg::MODE_16X8; {flip, a, b, c} = 4'b1111; end
                2: begin
                    mode = bbce_pkg::MODE_UNUSED;
                    {flip, a, b, c} = 4'($urandom_range(0, 15));
                end
                default: begin
                    mode = 2'($urandom_range(0, 3));
                    {flip, a, b, c} = 4'($urandom_range(0, 15));
                end
            endcase
            set_config(mode, flip, a, b, c);
            idle_en = (ph % 3 != 2);
            for (int n = 0; n < PHASE_WORDS; n++) begin
                bits = bbce_pkg::DATA_W'($urandom_range(0, 255));
                if ($urandom_range(0, 4) == 0) begin
                    if ($urandom_range(0, 9) == 0)
                        addr = bbce_pkg::ADDR_W'($urandom_range(bbce_pkg::COLOR_ROM_DEPTH,
                                                                8191));
                    else
                        addr = bbce_pkg::ADDR_W'($urandom_range(0,
                                                   bbce_pkg::COLOR_ROM_DEPTH - 1));
                    send_word(bbce_pkg::ACT_COLOR_LOAD, addr, bits);
                end
                else begin
                    addr = bbce_pkg::ADDR_W'($urandom_range(0, 8191));
                    send_video(addr, bits);
                end
            end
            wait_drained();
        end
        idle_en = 1'b1;
    endtask

    // The pixel sink holds off while words keep coming, so the input stalls.
    task automatic test_output_stall();
        idle_en   = 1'b0;
        sink_hold = SINK_HOLD;
        for (int n = 0; n < 24; n++)
            send_video(bbce_pkg::ADDR_W'($urandom_range(0, 8191)),
                       bbce_pkg::DATA_W'($urandom_range(0, 255)));
        idle_en = 1'b1;
        wait_drained();
    endtask

    // Pixel sink: random stalls per word when idle_en is set, plus a long hold on request.
    initial begin : pixel_sink
        int stall;
        @(negedge clk);
        forever begin
            if (sink_hold > 0)
            begin
                m_axis_tready = 1'b0;
                repeat (sink_hold) @(negedge clk);
                sink_hold = 0;
            end
            stall = idle_en ? $urandom_range(0, 6) : 0;
            if (stall > 0)
            begin
                m_axis_tready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_axis_tready = 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
            @(negedge clk);
        end
    end

    // Compare each pixel word with the oldest one owed.
    always @(posedge clk)
    begin : pixel_check
        pixel_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            pixels_checked++;
            if (pending_pixels.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: unexpected pixel x=%0d y=%0d color=%0d last=%0b", $time,
                             m_axis_tdata[7:0], m_axis_tdata[15:8], m_axis_tdata[19:16],
                             m_axis_tlast);
            end
            else begin
                want = pending_pixels.pop_front();
                if (m_axis_tdata[7:0] !== want.x || m_axis_tdata[15:8] !== want.y ||
                    m_axis_tdata[19:16] !== want.color || m_axis_tlast !== want.last) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: pixel mismatch expected x=%0d y=%0d color=%0d last=%0b, %s",
                                 $time, want.x, want.y, want.color, want.last,
                                 $sformatf("actual x=%0d y=%0d color=%0d last=%0b",
                                           m_axis_tdata[7:0], m_axis_tdata[15:8],
                                           m_axis_tdata[19:16], m_axis_tlast));
                end
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    // Reset once, then run the tests in turn.
    initial begin
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_random_phases();
        test_output_stall();
        wait_drained();
        repeat (8) @(negedge clk);
        $display("Covered %0d video words and %0d color loads over %0d register settings,",
                 video_words, color_loads, settings_used);
        $display("including a long output hold; %0d pixels checked, %0d mismatches.",
                 pixels_checked, mismatches);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
